@@ hw/rtl/pjtt_pkg.sv @@
// Shared types and codes for the periodic job timer table.
// No dependencies; imported by the request and response interfaces, the countdown unit, the table and its testbench.
package pjtt_pkg;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ID_W     = 4;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_WAKE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_SCHED = 2'd3
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAKE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Operations of the shared countdown unit.
  typedef enum logic [1:0] {
    OP_DEC    = 2'd0,
    OP_RELOAD = 2'd1,
    OP_LOAD   = 2'd2,
    OP_CLEAR  = 2'd3
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_EX,
    ST_FIN
  } state_t;

endpackage

@@ hw/rtl/pjtt_req_if.sv @@
// Request channel: valid/ready plus one input item.
// Depends on pjtt_pkg for field widths.
interface pjtt_req_if import pjtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [PERIOD_W-1:0] period;
  logic [INDEX_W-1:0]  job_index;

  modport source (output valid, mode, period, job_index, input ready);
  modport sink   (input valid, mode, period, job_index, output ready);
endinterface

@@ hw/rtl/pjtt_rsp_if.sv @@
// Response channel: valid/ready plus one result item.
// Depends on pjtt_pkg for field widths.
interface pjtt_rsp_if import pjtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              status;
  logic [ID_W-1:0]   job_id;
  logic              last;

  modport source (output valid, kind, status, job_id, last, input ready);
  modport sink   (input valid, kind, status, job_id, last, output ready);
endinterface

@@ hw/rtl/pjtt_cfg_if.sv @@
// Configuration write channel carrying the running flag.
// No dependencies.
interface pjtt_cfg_if;
  logic valid;
  logic ready;
  logic running;

  modport source (output valid, running, input ready);
  modport sink   (input valid, running, output ready);
endinterface

@@ hw/rtl/pjtt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pjtt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pjtt_alu.sv @@
// Shared countdown unit: decrement, reload on zero, load and clear.
// Depends on pjtt_pkg for alu_op_t.
module pjtt_alu import pjtt_pkg::*; (
  input  alu_op_t             op,
  input  logic [PERIOD_W-1:0] cur,
  input  logic [PERIOD_W-1:0] per,
  output logic [PERIOD_W-1:0] nxt,
  output logic                is_zero
);

  always_comb begin
    is_zero = (cur == '0);
    case (op)
      OP_DEC:    nxt = is_zero ? '0 : cur - PERIOD_W'(1);
      OP_RELOAD: nxt = is_zero ? per : cur;
      OP_LOAD:   nxt = per;
      OP_CLEAR:  nxt = '0;
      default:   nxt = '0;
    endcase
  end

endmodule

@@ hw/rtl/periodic_job_timer_table.sv @@
// Periodic job timer table. Holds up to MAX_JOBS periodic countdown timers,
// numbered 1..MAX_JOBS in the order they are added. One request beat is
// taken at a time; req.ready is high only while the sequencer is idle, and a
// result may still sit in the response register while the next request is
// taken. Add and wake go from idle through the execute state back to idle;
// the execute state waits until the response register is free. Tick and
// schedule walk the registered entries through one shared countdown unit and
// the timer RAMs at one read port: a read state and an execute state for each
// registered job, then a final read state that finds the end of the table and
// a closing state for the last result. A reply, due or final result waits in
// its state while the response register is full and rsp.ready is low.
// Timer and period storage need no clearing pass: an entry is always written
// by its add before a walk reads it. The running flag is written through cfg
// at any time, one beat per cycle.
module periodic_job_timer_table import pjtt_pkg::*; #(
  parameter int unsigned MAX_JOBS = 8
) (
  input logic          clk,
  input logic          rst,
  pjtt_req_if.sink     req,
  pjtt_rsp_if.source   rsp,
  pjtt_cfg_if.sink     cfg
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);

  state_t state, state_next;

  // Latched request payload.
  mode_t               mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic [INDEX_W-1:0]  idx_q;

  logic [CNT_W-1:0] cnt, cnt_next;     // registered job count, saturates
  logic [CNT_W-1:0] walk, walk_next;   // entry under the walk
  logic             running;

  // Response register.
  logic              ovalid;
  logic [KIND_W-1:0] okind;
  logic              ostatus;
  logic [ID_W-1:0]   oid;
  logic              olast;
  logic              out_free;

  // Result to load this cycle.
  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic              e_status;
  logic [ID_W-1:0]   e_id;
  logic              e_last;

  // RAM and shared unit wiring.
  logic                cd_we, per_we;
  logic [IDX_W-1:0]    waddr;
  logic [PERIOD_W-1:0] cd_rd, per_rd;
  logic [PERIOD_W-1:0] alu_per, alu_nxt;
  logic                alu_zero;
  alu_op_t             alu_op;

  logic                req_take;
  logic                wake_ok;
  logic [INDEX_W-1:0]  idx_m1;
  logic [CNT_W-1:0]    cnt_inc, walk_inc;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !ovalid || rsp.ready;

  assign cnt_inc  = cnt + CNT_W'(1);
  assign walk_inc = walk + CNT_W'(1);
  assign idx_m1   = idx_q - INDEX_W'(1);
  assign wake_ok  = running && (idx_q != '0) && (idx_q <= INDEX_W'(cnt));
  assign alu_per  = (state == ST_EXEC) ? period_q : per_rd;

  pjtt_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_JOBS)) u_cd_ram (
    .clk   (clk),
    .we    (cd_we),
    .waddr (waddr),
    .wdata (alu_nxt),
    .raddr (walk[IDX_W-1:0]),
    .rdata (cd_rd)
  );

  pjtt_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_JOBS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (waddr),
    .wdata (period_q),
    .raddr (walk[IDX_W-1:0]),
    .rdata (per_rd)
  );

  pjtt_alu u_alu (
    .op      (alu_op),
    .cur     (cd_rd),
    .per     (alu_per),
    .nxt     (alu_nxt),
    .is_zero (alu_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      walk    <= '0;
      running <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      walk  <= walk_next;
      if (cfg.valid && cfg.ready) begin
        running <= cfg.running;
      end
      if (emit) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the request and the pending result.
  always_ff @(posedge clk) begin
    if (req_take) begin
      mode_q   <= mode_t'(req.mode);
      period_q <= req.period;
      idx_q    <= req.job_index;
    end
    if (emit) begin
      okind   <= e_kind;
      ostatus <= e_status;
      oid     <= e_id;
      olast   <= e_last;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    walk_next  = walk;
    emit       = 1'b0;
    e_kind     = KIND_END;
    e_status   = STATUS_OK;
    e_id       = '0;
    e_last     = 1'b1;
    cd_we      = 1'b0;
    per_we     = 1'b0;
    waddr      = walk[IDX_W-1:0];
    alu_op     = OP_DEC;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          walk_next = '0;
          if (mode_t'(req.mode) == MODE_ADD || mode_t'(req.mode) == MODE_WAKE) begin
            state_next = ST_EXEC;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_EXEC: begin
        // Single-result items: commit the write together with the reply.
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (mode_q == MODE_ADD) begin
            e_kind = KIND_ADD;
            if (cnt < CNT_W'(MAX_JOBS)) begin
              waddr    = cnt[IDX_W-1:0];
              alu_op   = OP_LOAD;
              cd_we    = 1'b1;
              per_we   = 1'b1;
              cnt_next = cnt_inc;
              e_id     = ID_W'(cnt_inc);
            end else begin
              e_status = STATUS_ERR;
            end
          end else begin
            e_kind = KIND_WAKE;
            if (wake_ok) begin
              waddr  = idx_m1[IDX_W-1:0];
              alu_op = OP_CLEAR;
              cd_we  = 1'b1;
            end else begin
              e_status = STATUS_ERR;
            end
          end
        end
      end
      ST_RD: begin
        // Read of entry walk is in flight; stop once past the last job.
        if (walk == cnt) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_EX;
        end
      end
      ST_EX: begin
        if (mode_q == MODE_TICK) begin
          alu_op     = OP_DEC;
          cd_we      = 1'b1;
          walk_next  = walk_inc;
          state_next = ST_RD;
        end else begin
          alu_op = OP_RELOAD;
          if (alu_zero) begin
            // Due job: reload and report, or hold until the response frees.
            if (out_free) begin
              emit       = 1'b1;
              e_kind     = KIND_DUE;
              e_id       = ID_W'(walk_inc);
              e_last     = 1'b0;
              cd_we      = 1'b1;
              walk_next  = walk_inc;
              state_next = ST_RD;
            end
          end else begin
            walk_next  = walk_inc;
            state_next = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = (mode_q == MODE_TICK) ? KIND_TICK : KIND_END;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid  = ovalid;
  assign rsp.kind   = okind;
  assign rsp.status = ostatus;
  assign rsp.job_id = oid;
  assign rsp.last   = olast;

  // The job count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_JOBS))
    else $error("job count above table size");

  // Only due-job beats leave with last clear.
  a_nonlast_due: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> (rsp.kind == KIND_DUE))
    else $error("non-final beat that is not a due job");

  // A walk step only ever looks at a registered entry.
  a_walk_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EX) |-> (walk < cnt))
    else $error("walk beyond registered jobs");

  // Taking a request closes the request port for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_take |=> !req.ready)
    else $error("request taken while busy");

  // The count changes only through a successful add.
  a_cnt_add_only: assert property (@(posedge clk) disable iff (rst)
    (cnt != cnt_next) |-> (state == ST_EXEC && mode_q == MODE_ADD))
    else $error("job count changed outside an add");

endmodule

@@ sim/tb_periodic_job_timer_table.sv @@
// Self-checking testbench for periodic_job_timer_table: directed and random
// add, wake, tick and schedule beats against a shadow copy of the timer table.
// Depends on pjtt_pkg and the request, response and config interfaces.
module tb_periodic_job_timer_table;
  import pjtt_pkg::*;

  localparam int unsigned MAX_JOBS      = 8;
  // The limit lies far beyond a full walk and its usual response stalls, so
  // reaching it can only mean a hang.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Quiet cycles after the last owed result, enough for a full-table walk.
  localparam int unsigned SETTLE_CYCLES = 24;

  // Response-side stall styles, one picked at random each time the low six bits of rx_count return to zero.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready with probability three in four, at random
    RX_COMB     // fixed comb: ready while rx_count modulo five is below two
  } rx_style_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [ID_W-1:0]   job_id;
    logic              last;
  } timer_result_t;

  // Shadow of the timer table. Each accepted request beat updates the copy and
  // queues the result beats it owes; each result beat is matched in order.
  class timer_table_shadow;
    logic [PERIOD_W-1:0] countdown [MAX_JOBS];
    logic [PERIOD_W-1:0] reload    [MAX_JOBS];
    int unsigned         job_count;
    logic                running;
    timer_result_t       owed [$];
    int unsigned         mismatches;
    int unsigned         beats_in;
    int unsigned         beats_out;
    int unsigned         due_beats;
    int unsigned         refused;

    function new();
      foreach (countdown[i]) begin
        countdown[i] = '0;
        reload[i]    = '0;
      end
      job_count  = 0;
      running    = 1'b0;
      mismatches = 0;
      beats_in   = 0;
      beats_out  = 0;
      due_beats  = 0;
      refused    = 0;
    endfunction

    function void owe(logic [KIND_W-1:0] kind, logic status, int unsigned id, logic last);
      timer_result_t r;
      r.kind   = kind;
      r.status = status;
      r.job_id = id[ID_W-1:0];
      r.last   = last;
      owed.push_back(r);
    endfunction

    function void take_request(mode_t mode, logic [PERIOD_W-1:0] period,
                               logic [INDEX_W-1:0] index);
      beats_in++;
      case (mode)
        MODE_ADD: begin
          if (job_count < MAX_JOBS) begin
            reload[job_count]    = period;
            countdown[job_count] = period;
            job_count++;
            owe(KIND_ADD, STATUS_OK, job_count, 1'b1);
          end else begin
            refused++;
            owe(KIND_ADD, STATUS_ERR, 0, 1'b1);
          end
        end
        MODE_WAKE: begin
          if (running && index >= 1 && index <= job_count) begin
            countdown[index - 1] = '0;
            owe(KIND_WAKE, STATUS_OK, 0, 1'b1);
          end else begin
            refused++;
            owe(KIND_WAKE, STATUS_ERR, 0, 1'b1);
          end
        end
        MODE_TICK: begin
          for (int i = 0; i < job_count; i++)
            if (countdown[i] != '0) countdown[i]--;
          owe(KIND_TICK, STATUS_OK, 0, 1'b1);
        end
        default: begin
          for (int i = 0; i < job_count; i++) begin
            if (countdown[i] == '0) begin
              countdown[i] = reload[i];
              owe(KIND_DUE, STATUS_OK, i + 1, 1'b0);
            end
          end
          owe(KIND_END, STATUS_OK, 0, 1'b1);
        end
      endcase
    endfunction

    function void match_result(timer_result_t got);
      timer_result_t want;
      beats_out++;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: kind %0d job_id %0d", got.kind, got.job_id);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (want.kind == KIND_DUE) due_beats++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.job_id !== want.job_id) begin
        $error("job_id: expected %0d, got %0d", want.job_id, got.job_id);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pjtt_req_if req ();
  pjtt_rsp_if rsp ();
  pjtt_cfg_if cfg ();

  periodic_job_timer_table #(.MAX_JOBS(MAX_JOBS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  timer_table_shadow shadow;
  int unsigned       burst_left;
  int unsigned       stall_cycles = 0;
  logic [7:0]        rx_count     = '0;
  rx_style_t         rx_style     = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: stall on a pattern of its own, independent of the sender.
  always @(posedge clk) begin
    rx_count <= rx_count + 8'd1;
    if (rx_count[5:0] == 6'd0) rx_style <= rx_style_t'($urandom_range(0, 2));
    case (rx_style)
      RX_OPEN: rsp.ready <= 1'b1;
      RX_COIN: rsp.ready <= ($urandom_range(0, 3) != 0);
      default: rsp.ready <= ((rx_count % 5) < 2);
    endcase
  end

  // Monitor: sample every handshake at the edge, before any driver update.
  // Match results first; a result beat never belongs to a request taken
  // at the same edge.
  always @(posedge clk) begin
    timer_result_t got;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.kind   = rsp.kind;
        got.status = rsp.status;
        got.job_id = rsp.job_id;
        got.last   = rsp.last;
        shadow.match_result(got);
      end
      if (req.valid && req.ready)
        shadow.take_request(mode_t'(req.mode), req.period, req.job_index);
      if (cfg.valid && cfg.ready)
        shadow.running = cfg.running;
    end
  end

  // Watchdog: count edges with no beat on any channel; give up at the limit.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one request beat. Work in bursts: when a burst runs out, drop valid
  // for a random gap (often none), then start a new burst. Hold valid high
  // between beats of a burst so each next request is offered as soon as the table is idle again.
  task automatic push_request(mode_t mode, logic [PERIOD_W-1:0] period,
                              logic [INDEX_W-1:0] index);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.period    <= period;
    req.job_index <= index;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending and wait until every owed result beat has come back.
  // Check on the falling edge so the monitor has already run for the cycle.
  task automatic hold_until_drained();
    req.valid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (shadow.owed.size() != 0);
    @(posedge clk);
  endtask

  // Write the running flag; call only with the table drained.
  task automatic write_running(logic value);
    cfg.valid   <= 1'b1;
    cfg.running <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Random beat: mostly ticks, passes and wakes of registered jobs, with a
  // share of out-of-range wakes and adds against the full table.
  task automatic random_request();
    int unsigned        pick;
    logic [INDEX_W-1:0] index;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_request(MODE_ADD, PERIOD_W'($urandom), INDEX_W'($urandom));
    end else if (pick < 35) begin
      if ($urandom_range(0, 5) == 0) index = INDEX_W'($urandom_range(0, 255));
      else index = INDEX_W'($urandom_range(1, MAX_JOBS));
      push_request(MODE_WAKE, PERIOD_W'($urandom), index);
    end else if (pick < 70) begin
      push_request(MODE_TICK, PERIOD_W'($urandom), INDEX_W'($urandom));
    end else begin
      push_request(MODE_SCHED, PERIOD_W'($urandom), INDEX_W'($urandom));
    end
  endtask

  initial begin
    shadow        = new();
    burst_left    = 0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.mode      <= MODE_ADD;
    req.period    <= '0;
    req.job_index <= '0;
    cfg.valid     <= 1'b0;
    cfg.running   <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, scheduler stopped: refuse wakes, tick and pass over nothing.
    push_request(MODE_WAKE, '0, 8'd0);
    push_request(MODE_WAKE, '1, 8'd255);
    push_request(MODE_TICK, '0, '0);
    push_request(MODE_SCHED, '0, '0);
    // Register jobs with zero, one, all-ones and small periods.
    push_request(MODE_ADD, 32'd0, '0);
    push_request(MODE_ADD, 32'd1, '0);
    push_request(MODE_ADD, 32'hFFFF_FFFF, '0);
    push_request(MODE_ADD, 32'd2, '0);
    // Wake of a registered job is still refused while stopped.
    push_request(MODE_WAKE, '0, 8'd1);
    push_request(MODE_SCHED, '0, '0);
    push_request(MODE_TICK, '0, '0);
    push_request(MODE_SCHED, '0, '0);

    // Start the scheduler; hold the sender until the table is idle.
    hold_until_drained();
    write_running(1'b1);
    push_request(MODE_WAKE, '0, 8'd3);
    push_request(MODE_WAKE, '0, 8'd5);
    push_request(MODE_WAKE, '0, 8'd0);
    push_request(MODE_SCHED, '0, '0);
    // Fill the table, then overflow it.
    push_request(MODE_ADD, 32'd3, '0);
    push_request(MODE_ADD, 32'd1, '0);
    push_request(MODE_ADD, 32'd4, '0);
    push_request(MODE_ADD, 32'd0, '0);
    push_request(MODE_ADD, 32'd7, '0);
    push_request(MODE_TICK, '0, '0);
    push_request(MODE_SCHED, '0, '0);
    push_request(MODE_WAKE, '0, 8'(MAX_JOBS));
    push_request(MODE_WAKE, '0, 8'(MAX_JOBS + 1));

    // Random traffic: running, then stopped, then running again.
    repeat (45) random_request();
    hold_until_drained();
    write_running(1'b0);
    repeat (20) random_request();
    hold_until_drained();
    write_running(1'b1);
    repeat (40) random_request();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.owed.size() != 0) begin
      $error("%0d result beats never arrived", shadow.owed.size());
      shadow.mismatches++;
    end

    $display("covered %0d request beats and %0d result beats, %0d of them due reports",
             shadow.beats_in, shadow.beats_out, shadow.due_beats);
    $display("refused adds and wakes: %0d; table ended with %0d registered jobs",
             shadow.refused, shadow.job_count);
    if (shadow.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
